// File: design/icl_pkg.sv
// shared types and constants for the idle-count cpu load estimator
// used by icl_lane, icl_merge and idle_count_cpu_load_estimator_core
`default_nettype none
package icl_pkg;

  localparam int NUM_CPUS = 2;
  localparam int LANE_COUNT = (NUM_CPUS < 1) ? 1 : ((NUM_CPUS > 2) ? 2 : NUM_CPUS);

  localparam int CNT_W = 32;
  localparam int PCT_W = 7;
  localparam int SUM_W = PCT_W + 1;
  localparam int ITER_W = $clog2(CNT_W);

  localparam logic [CNT_W-1:0] PEAK_DECAY_FLOOR = 32'd8;
  localparam int PEAK_DECAY_SHIFT = 7;
  localparam logic [PCT_W-1:0] PERCENT_FULL = 7'd100;

  typedef enum logic [1:0] {
    LANE_IDLE,
    LANE_PEAK,
    LANE_DIV,
    LANE_DONE
  } lane_state_t;

  typedef enum logic {
    CORE_IDLE,
    CORE_BUSY
  } core_state_t;

  typedef struct packed {
    logic start;
    logic release_lane;
  } lane_ctl_t;

  typedef struct packed {
    logic done;
  } lane_sts_t;

endpackage
`default_nettype wire

// File: design/idle_count_cpu_load_estimator_core.sv
// idle-count cpu load estimator: one lane per cpu
// lane steps: delta registered on start, peak update, 32-step serial divide, then done
// a lane takes no new sample until its 32-step divide is done and the result is loaded;
// the next sample is taken while the previous result still waits in the output register
// sync reset: previous counters cleared, peak of cpu 0 set to one, others to zero
`default_nettype none
module idle_count_cpu_load_estimator_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] idle_count_first,
  input  wire logic [31:0] idle_count_second,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [6:0]       load_percent
);
  import icl_pkg::*;

  core_state_t state, state_next;
  lane_ctl_t   ctl;
  lane_sts_t   sts [LANE_COUNT];
  logic [PCT_W-1:0] lane_pct [LANE_COUNT];
  logic [CNT_W-1:0] counts [2];
  logic all_done;
  logic out_free;
  logic load_en;

  assign counts[0] = idle_count_first;
  assign counts[1] = idle_count_second;

  always_comb begin
    all_done = 1'b1;
    for (int i = 0; i < LANE_COUNT; i++) begin
      all_done = all_done & sts[i].done;
    end
  end

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    ctl = '0;
    load_en = 1'b0;
    in_stall = 1'b1;
    case (state)
      CORE_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.start = 1'b1;
          state_next = CORE_BUSY;
        end
      end
      CORE_BUSY: begin
        // result leaves the lanes only once the output register can take it
        if (all_done && out_free) begin
          load_en = 1'b1;
          ctl.release_lane = 1'b1;
          state_next = CORE_IDLE;
        end
      end
      default: state_next = CORE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CORE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
    icl_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .count     (counts[g]),
      .peak_init ((g == 0) ? 32'd1 : 32'd0),
      .sts       (sts[g]),
      .idle_pct  (lane_pct[g])
    );
  end

  icl_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .load_en      (load_en),
    .lane_pct     (lane_pct),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .load_percent (load_percent)
  );

endmodule
`default_nettype wire

// File: design/icl_lane.sv
// one per-cpu lane: wrapping delta, peak tracking and a serial idle-percent divider
// depends on icl_pkg
`default_nettype none
module icl_lane (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire icl_pkg::lane_ctl_t      ctl,
  input  wire logic [31:0]             count,
  input  wire logic [31:0]             peak_init,
  output icl_pkg::lane_sts_t           sts,
  output logic [6:0]                   idle_pct
);
  import icl_pkg::*;

  lane_state_t state, state_next;

  logic [CNT_W-1:0]  previous_idle;
  logic [CNT_W-1:0]  peak_delta;
  logic [CNT_W-1:0]  delta;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  quo;
  logic [CNT_W-1:0]  dvsr;
  logic [ITER_W-1:0] iter;

  logic [CNT_W-1:0]       step;
  logic [CNT_W-1:0]       decayed;
  logic [CNT_W-1:0]       peak_next;
  logic [CNT_W+PCT_W-1:0] prod_full;
  logic [CNT_W:0]         trial;
  logic [CNT_W:0]         diff;

  // peak update, done in the cycle after the delta is registered
  always_comb begin
    step = peak_delta >> PEAK_DECAY_SHIFT;
    if (step == '0) begin
      step = {{(CNT_W-1){1'b0}}, 1'b1};
    end
    decayed = peak_delta - step;
    if (delta > peak_delta) begin
      peak_next = delta;
    end else if (peak_delta > PEAK_DECAY_FLOOR) begin
      peak_next = (delta > decayed) ? delta : decayed;
    end else begin
      peak_next = peak_delta;
    end
  end

  assign prod_full = delta * PERCENT_FULL;
  assign trial = {rem, quo[CNT_W-1]};
  assign diff = trial - {1'b0, dvsr};

  always_comb begin
    state_next = state;
    case (state)
      LANE_IDLE: if (ctl.start) state_next = LANE_PEAK;
      LANE_PEAK: state_next = LANE_DIV;
      LANE_DIV:  if (iter == ITER_W'(CNT_W - 1)) state_next = LANE_DONE;
      LANE_DONE: if (ctl.release_lane) state_next = LANE_IDLE;
      default:   state_next = LANE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LANE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_idle <= '0;
      peak_delta <= peak_init;
    end else begin
      if (state == LANE_IDLE && ctl.start) begin
        previous_idle <= count;
      end
      if (state == LANE_PEAK) begin
        peak_delta <= peak_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      LANE_IDLE: begin
        if (ctl.start) delta <= count - previous_idle;
      end
      LANE_PEAK: begin
        quo  <= prod_full[CNT_W-1:0];
        rem  <= '0;
        dvsr <= (peak_next == '0) ? {{(CNT_W-1){1'b0}}, 1'b1} : peak_next;
        iter <= '0;
      end
      LANE_DIV: begin
        // restoring division, one quotient bit per cycle
        if (!diff[CNT_W]) begin
          rem <= diff[CNT_W-1:0];
          quo <= {quo[CNT_W-2:0], 1'b1};
        end else begin
          rem <= trial[CNT_W-1:0];
          quo <= {quo[CNT_W-2:0], 1'b0};
        end
        iter <= iter + ITER_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign sts.done = (state == LANE_DONE);
  assign idle_pct = (quo > CNT_W'(PERCENT_FULL)) ? PERCENT_FULL : quo[PCT_W-1:0];

endmodule
`default_nettype wire

// File: design/icl_merge.sv
// merge stage: averages lane idle percents, forms the load and holds the output beat
// depends on icl_pkg
`default_nettype none
module icl_merge (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load_en,
  input  wire logic [6:0] lane_pct [icl_pkg::LANE_COUNT],
  input  wire logic       out_stall,
  output logic            out_valid,
  output logic [6:0]      load_percent
);
  import icl_pkg::*;

  logic [SUM_W-1:0] total;
  logic [SUM_W-1:0] avg;
  logic [PCT_W-1:0] avg_clamped;

  always_comb begin
    total = '0;
    for (int i = 0; i < LANE_COUNT; i++) begin
      total = total + SUM_W'(lane_pct[i]);
    end
    avg = SUM_W'(total / LANE_COUNT);
    avg_clamped = (avg > SUM_W'(PERCENT_FULL)) ? PERCENT_FULL : avg[PCT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      load_percent <= PERCENT_FULL - avg_clamped;
    end
  end

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// testbench for idle_count_cpu_load_estimator_core: random and directed idle-counter samples
// a scoreboard class predicts load_percent per sample; depends on icl_pkg and the core
module tb;
  import icl_pkg::*;

  class load_scoreboard;
    logic [CNT_W-1:0] last_count [2];
    logic [CNT_W-1:0] peak [2];
    logic [PCT_W-1:0] expected_q [$];
    int errors;

    function new();
      last_count[0] = '0;
      last_count[1] = '0;
      peak[0] = 32'd1;
      peak[1] = '0;
      errors = 0;
    endfunction

    function logic [CNT_W-1:0] cpu_idle_pct(int cpu, logic [CNT_W-1:0] count);
      logic [CNT_W-1:0] delta;
      logic [CNT_W-1:0] step;
      logic [CNT_W-1:0] divisor;
      logic [CNT_W-1:0] pct;
      delta = count - last_count[cpu];
      last_count[cpu] = count;
      if (delta > peak[cpu]) begin
        peak[cpu] = delta;
      end else if (peak[cpu] > PEAK_DECAY_FLOOR) begin
        step = peak[cpu] >> PEAK_DECAY_SHIFT;
        if (step == '0) step = 32'd1;
        peak[cpu] = peak[cpu] - step;
        if (delta > peak[cpu]) peak[cpu] = delta;
      end
      divisor = (peak[cpu] == '0) ? 32'd1 : peak[cpu];
      // product wraps at 32 bits before the divide
      pct = (delta * 32'(PERCENT_FULL)) / divisor;
      if (pct > 32'(PERCENT_FULL)) pct = 32'(PERCENT_FULL);
      return pct;
    endfunction

    function void note_sample(logic [CNT_W-1:0] first, logic [CNT_W-1:0] second);
      logic [CNT_W-1:0] total;
      logic [CNT_W-1:0] avg;
      total = cpu_idle_pct(0, first);
      if (LANE_COUNT > 1) total = total + cpu_idle_pct(1, second);
      avg = total / 32'(LANE_COUNT);
      if (avg > 32'(PERCENT_FULL)) avg = 32'(PERCENT_FULL);
      expected_q.push_back(PCT_W'(32'(PERCENT_FULL) - avg));
    endfunction

    function void check_load(logic [PCT_W-1:0] actual);
      logic [PCT_W-1:0] expected;
      if (expected_q.size() == 0) begin
        $display("%0t load_percent beat with nothing expected: expected none actual %0d",
                 $time, actual);
        errors++;
      end else begin
        expected = expected_q.pop_front();
        if (actual !== expected) begin
          $display("%0t load_percent mismatch: expected %0d actual %0d",
                   $time, expected, actual);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] idle_count_first = '0;
  logic [31:0] idle_count_second = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [6:0] load_percent;

  load_scoreboard board = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  logic [31:0] sent_first = '0;
  logic [31:0] sent_second = '0;

  idle_count_cpu_load_estimator_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .idle_count_first(idle_count_first),
    .idle_count_second(idle_count_second),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .load_percent(load_percent)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random stall, plus one long hold-off so the core backs up
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_request && !hold_done) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_load(load_percent);
  end

  task send_sample(input logic [31:0] first, input logic [31:0] second);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    idle_count_first <= first;
    idle_count_second <= second;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_sample(first, second);
    sent_first = first;
    sent_second = second;
  endtask

  task send_step(input logic [31:0] delta_first, input logic [31:0] delta_second);
    send_sample(sent_first + delta_first, sent_second + delta_second);
  endtask

  function logic [31:0] pick_delta(logic [31:0] scale);
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 80) return $urandom_range(scale);
    if (r < 90) return scale - $urandom_range(3);
    return scale + $urandom_range(scale);
  endfunction

  initial begin
    int i;
    int expo;
    logic [31:0] scale;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero peak on cpu 1 and the decay floor while peaks are still small
    send_sample(32'd0, 32'd0);
    send_step(32'd9, 32'd9);
    send_step(32'd0, 32'd0);
    send_step(32'd0, 32'd0);
    send_step(32'd3, 32'd8);
    send_step(32'd200, 32'd150);
    send_step(32'd100, 32'd149);
    send_step(32'd199, 32'd0);
    send_step(32'd1, 32'd148);
    // counter wrap with a small delta
    send_sample(32'hFFFF_FFF0, 32'hFFFF_FF80);
    send_sample(32'h0000_0010, 32'h0000_0005);
    // percent product overflow
    send_step(32'd50_000_000, 32'd45_000_000);
    send_step(32'd49_000_000, 32'd1);
    send_sample(32'hFFFF_FFFF, 32'h0000_0000);
    send_sample(32'h0000_0000, 32'hFFFF_FFFF);
    send_sample(32'hAAAA_AAAA, 32'h5555_5555);
    send_sample(32'h5555_5555, 32'hAAAA_AAAA);
    send_step(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_step(32'd0, 32'd0);
    send_step(32'd1, 32'd1);

    // random samples: growing delta scale, counter noise near the end
    for (i = 0; i < 950; i++) begin
      if (i == 0) begin
        send_idle_pct = 19;
        recv_idle_pct = 45;
      end else if (i == 320) begin
        send_idle_pct = 45;
        recv_idle_pct = 19;
      end else if (i == 640) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (i == 100) hold_request = 1'b1;
      expo = 3 + (i * 28) / 800;
      if (expo > 31) expo = 31;
      scale = 32'd1 << expo;
      if (i >= 800 && $urandom_range(99) < 30) begin
        if ($urandom_range(1)) send_sample($urandom(), $urandom());
        else send_step(32'hFFFF_FFFF - $urandom_range(255), $urandom());
      end else begin
        send_step(pick_delta(scale), pick_delta(scale));
      end
    end
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.errors == 0) begin
      $display("[idle_count_cpu_load_estimator_core] OK");
    end else begin
      $display("[idle_count_cpu_load_estimator_core] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[idle_count_cpu_load_estimator_core] ERROR");
    $finish;
  end
endmodule
